### rtl/hcbd_pkg.sv
package hcbd_pkg;

  // Decoder phase within the chunked framing
  typedef enum logic [2:0] {
    PH_DIGITS    = 3'd0,
    PH_DIGITS_CR = 3'd1,
    PH_EXT       = 3'd2,
    PH_EXT_CR    = 3'd3,
    PH_DATA      = 3'd4,
    PH_DATA_LF   = 3'd5,
    PH_DONE      = 3'd6,
    PH_ERROR     = 3'd7
  } phase_t;

  // Framing characters
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_SEMI = 8'h3B;

  // Header line length limit register
  localparam int unsigned LIMIT_W = 13;
  localparam logic [LIMIT_W-1:0] LIMIT_CAP   = 13'd4096;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd1024;

  // Classification of one incoming character
  typedef struct packed {
    logic       is_hex;
    logic [3:0] hex_val;
    logic       is_cr;
    logic       is_lf;
    logic       is_semi;
  } char_class_t;

endpackage

### rtl/hcbd_classify.sv
module hcbd_classify (
  input  logic [7:0]                 ch,
  output hcbd_pkg::char_class_t      cls
);

  // Decode hex digits and the framing characters
  always_comb begin
    cls.is_hex  = 1'b0;
    cls.hex_val = 4'd0;
    if (ch inside {[8'h30:8'h39]}) begin
      cls.is_hex  = 1'b1;
      cls.hex_val = ch[3:0];
    end else if (ch inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      cls.is_hex  = 1'b1;
      cls.hex_val = ch[3:0] + 4'd9;
    end
    cls.is_cr   = (ch == hcbd_pkg::CHAR_CR);
    cls.is_lf   = (ch == hcbd_pkg::CHAR_LF);
    cls.is_semi = (ch == hcbd_pkg::CHAR_SEMI);
  end

endmodule

### rtl/http_chunked_body_decoder_core.sv
// Decodes an HTTP/1.1 chunked body one byte per clock unless stalled:
// every accepted byte gives exactly one output word, carrying the byte
// itself when it is chunk payload, plus sticky stream_done and frame_error
// flags. Header size digits (1..MAX_SIZE_DIGITS hex), ';' extensions, the
// CRLF after each payload and the final zero-size chunk are checked in a
// single registered update; the longest path is the payload down-counter
// of 4*MAX_SIZE_DIGITS bits with its zero test. The output register lets
// a new byte enter while the previous word is still held; in_stall rises
// only when that word is stalled. header_limit is written through the cfg
// port (always ready) and should only change while the decoder is idle.
module http_chunked_body_decoder_core #(
  parameter int unsigned MAX_SIZE_DIGITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // byte input
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_byte,
  // result output
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    data_byte,
  output logic                          is_payload,
  output logic                          stream_done,
  output logic                          frame_error,
  // header_limit register write
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [hcbd_pkg::LIMIT_W-1:0]  cfg_data
);

  localparam int unsigned SIZE_W = 4 * MAX_SIZE_DIGITS;
  localparam int unsigned DCNT_W = $clog2(MAX_SIZE_DIGITS + 1);
  localparam int unsigned HC_W   = hcbd_pkg::LIMIT_W;
  localparam logic [DCNT_W-1:0] DIGITS_MAX = DCNT_W'(MAX_SIZE_DIGITS);

  // State
  logic [HC_W-1:0]       header_limit;
  hcbd_pkg::phase_t      phase, phase_next;
  logic [SIZE_W-1:0]     size_value, size_value_next;
  logic [DCNT_W-1:0]     digit_count, digit_count_next;
  logic [HC_W-1:0]       header_count, header_count_next;
  logic [SIZE_W-1:0]     bytes_left, bytes_left_next;
  logic                  last_chunk, last_chunk_next;
  logic                  payload;

  logic                  accept;
  hcbd_pkg::char_class_t cls;
  logic [HC_W-1:0]       lim;
  logic [HC_W:0]         hc_plus1;
  logic                  cnt_full, cnt_full2, left_zero;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid & out_stall;
  assign accept    = in_valid & ~in_stall;

  hcbd_classify u_classify (
    .ch  (in_byte),
    .cls (cls)
  );

  // Header length checks for one and for two more content bytes
  assign lim       = (header_limit > hcbd_pkg::LIMIT_CAP) ? hcbd_pkg::LIMIT_CAP : header_limit;
  assign hc_plus1  = {1'b0, header_count} + {{HC_W{1'b0}}, 1'b1};
  assign cnt_full  = (header_count >= lim);
  assign cnt_full2 = (hc_plus1 >= {1'b0, lim});
  assign left_zero = (bytes_left == '0);

  // Next phase
  always_comb begin
    phase_next = phase;
    case (phase)
      hcbd_pkg::PH_DIGITS: begin
        if (cls.is_cr || cls.is_semi) begin
          if (digit_count == '0)  phase_next = hcbd_pkg::PH_ERROR;
          else if (cls.is_cr)     phase_next = hcbd_pkg::PH_DIGITS_CR;
          else if (cnt_full)      phase_next = hcbd_pkg::PH_ERROR;
          else                    phase_next = hcbd_pkg::PH_EXT;
        end else if (!cls.is_hex || digit_count >= DIGITS_MAX || cnt_full) begin
          phase_next = hcbd_pkg::PH_ERROR;
        end
      end
      hcbd_pkg::PH_DIGITS_CR: begin
        phase_next = cls.is_lf ? hcbd_pkg::PH_DATA : hcbd_pkg::PH_ERROR;
      end
      hcbd_pkg::PH_EXT: begin
        if (cls.is_cr)       phase_next = hcbd_pkg::PH_EXT_CR;
        else if (cnt_full)   phase_next = hcbd_pkg::PH_ERROR;
      end
      hcbd_pkg::PH_EXT_CR: begin
        if (cls.is_lf)       phase_next = hcbd_pkg::PH_DATA;
        else if (cnt_full)   phase_next = hcbd_pkg::PH_ERROR;
        else if (cls.is_cr)  phase_next = hcbd_pkg::PH_EXT_CR;
        else if (cnt_full2)  phase_next = hcbd_pkg::PH_ERROR;
        else                 phase_next = hcbd_pkg::PH_EXT;
      end
      hcbd_pkg::PH_DATA: begin
        if (left_zero) begin
          phase_next = cls.is_cr ? hcbd_pkg::PH_DATA_LF : hcbd_pkg::PH_ERROR;
        end
      end
      hcbd_pkg::PH_DATA_LF: begin
        if (!cls.is_lf)      phase_next = hcbd_pkg::PH_ERROR;
        else if (last_chunk) phase_next = hcbd_pkg::PH_DONE;
        else                 phase_next = hcbd_pkg::PH_DIGITS;
      end
      hcbd_pkg::PH_DONE:  phase_next = hcbd_pkg::PH_DONE;
      default:            phase_next = hcbd_pkg::PH_ERROR;
    endcase
  end

  // Datapath updates and payload flag
  always_comb begin
    size_value_next   = size_value;
    digit_count_next  = digit_count;
    header_count_next = header_count;
    bytes_left_next   = bytes_left;
    last_chunk_next   = last_chunk;
    payload           = 1'b0;
    case (phase)
      hcbd_pkg::PH_DIGITS: begin
        if (cls.is_semi) begin
          if (digit_count != '0 && !cnt_full) header_count_next = hc_plus1[HC_W-1:0];
        end else if (!cls.is_cr && cls.is_hex && digit_count < DIGITS_MAX && !cnt_full) begin
          size_value_next   = (size_value << 4) | SIZE_W'(cls.hex_val);
          digit_count_next  = digit_count + DCNT_W'(1);
          header_count_next = hc_plus1[HC_W-1:0];
        end
      end
      hcbd_pkg::PH_DIGITS_CR, hcbd_pkg::PH_EXT_CR: begin
        if (cls.is_lf) begin
          // header done: load the payload count
          bytes_left_next   = size_value;
          last_chunk_next   = (size_value == '0);
          size_value_next   = '0;
          digit_count_next  = '0;
          header_count_next = '0;
        end else if (phase == hcbd_pkg::PH_EXT_CR && !cnt_full) begin
          // held CR counts as content, then this byte unless it is a CR
          if (!cls.is_cr && !cnt_full2) header_count_next = header_count + HC_W'(2);
          else                          header_count_next = hc_plus1[HC_W-1:0];
        end
      end
      hcbd_pkg::PH_EXT: begin
        if (!cls.is_cr && !cnt_full) header_count_next = hc_plus1[HC_W-1:0];
      end
      hcbd_pkg::PH_DATA: begin
        if (!left_zero) begin
          bytes_left_next = bytes_left - SIZE_W'(1);
          payload         = 1'b1;
        end
      end
      hcbd_pkg::PH_DATA_LF: begin
        if (cls.is_lf && !last_chunk) begin
          size_value_next   = '0;
          digit_count_next  = '0;
          header_count_next = '0;
        end
      end
      default: ;
    endcase
  end

  // Hold the header_limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      header_limit <= hcbd_pkg::LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      header_limit <= cfg_data;
    end
  end

  // Advance decoder state on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= hcbd_pkg::PH_DIGITS;
      size_value   <= '0;
      digit_count  <= '0;
      header_count <= '0;
      bytes_left   <= '0;
      last_chunk   <= 1'b0;
    end else if (accept) begin
      phase        <= phase_next;
      size_value   <= size_value_next;
      digit_count  <= digit_count_next;
      header_count <= header_count_next;
      bytes_left   <= bytes_left_next;
      last_chunk   <= last_chunk_next;
    end
  end

  // Output word valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Load the output word
  always_ff @(posedge clk) begin
    if (accept) begin
      data_byte   <= payload ? in_byte : 8'd0;
      is_payload  <= payload;
      stream_done <= (phase_next == hcbd_pkg::PH_DONE);
      frame_error <= (phase_next == hcbd_pkg::PH_ERROR);
    end
  end

endmodule

### rtl/hcbd_checker.sv
module hcbd_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] data_byte,
  input logic       is_payload,
  input logic       stream_done,
  input logic       frame_error
);

  logic seen_err;
  logic seen_done;

  // Remember delivered error and end-of-stream words
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_err  <= 1'b0;
      seen_done <= 1'b0;
    end else if (out_valid && !out_stall) begin
      if (frame_error) seen_err  <= 1'b1;
      if (stream_done) seen_done <= 1'b1;
    end
  end

  // Error flag stays up once delivered
  assert property (@(posedge clk) disable iff (rst)
    out_valid && seen_err |-> frame_error)
    else $error("frame_error dropped after an error word");

  // Done flag stays up once delivered
  assert property (@(posedge clk) disable iff (rst)
    out_valid && seen_done |-> stream_done)
    else $error("stream_done dropped after the stream ended");

  // Non-payload words carry a zero byte
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_payload |-> data_byte == 8'd0)
    else $error("data_byte nonzero on a non-payload word");

  // Payload, done and error are mutually exclusive
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(stream_done && frame_error) && !(is_payload && (stream_done || frame_error)))
    else $error("conflicting flags on an output word");

  // No word right after reset
  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output word valid right after reset");

endmodule

bind http_chunked_body_decoder_core hcbd_checker u_hcbd_checker (.*);
